// File: hw/rtl/assert_macros.svh
// assertion macros for the checker file
// no dependencies; the includer provides clk and rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/tspcr_pkg.sv
// package for the transport-stream sync and pcr extractor
// constants, result record and port widths; no dependencies
`timescale 1ns / 1ps

package tspcr_pkg;

  // window geometry
  localparam int MAX_PACKET_BYTES = 204;
  localparam int WINDOW_DEPTH     = 3 * MAX_PACKET_BYTES;
  // the newest byte is never looked at before it moves, so one slot less is stored
  localparam int TAP_DEPTH        = WINDOW_DEPTH - 1;
  localparam int FILL_W           = $clog2(WINDOW_DEPTH);

  // packet lengths, tried in this order
  localparam int LEN_W = 8;
  localparam logic [LEN_W-1:0] LEN_188 = LEN_W'(188);
  localparam logic [LEN_W-1:0] LEN_196 = LEN_W'(196);
  localparam logic [LEN_W-1:0] LEN_204 = LEN_W'(204);

  // header codes
  localparam logic [7:0] SYNC_BYTE     = 8'h47;
  localparam logic [7:0] PID_HI_MASK   = 8'h1F;
  localparam logic [7:0] AF_PRESENT    = 8'h20;
  localparam logic [7:0] PCR_FLAG      = 8'h10;
  localparam logic [7:0] AF_MIN_LENGTH = 8'd7;

  localparam int PID_W = 13;
  localparam int PCR_W = 33;

  // stream port widths
  localparam int PAYLOAD_W = 8 + LEN_W + PID_W + PCR_W;
  localparam int TDATA_W   = ((PAYLOAD_W + 7) / 8) * 8;
  localparam int PAD_W     = TDATA_W - PAYLOAD_W;
  localparam int TUSER_W   = 2;
  localparam int IN_DATA_W = 8;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             packet_first;
    logic             packet_last;
    logic [LEN_W-1:0] packet_length;
    logic             pcr_valid;
    logic [PID_W-1:0] pcr_pid;
    logic [PCR_W-1:0] pcr_base;
  } result_t;

endpackage

// File: hw/rtl/tspcr_sync.sv
// lookahead window, sync search and pcr decode for one byte per beat
// depends on tspcr_pkg
`timescale 1ns / 1ps

module tspcr_sync (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_accept,
  input  logic [7:0]       data_byte,
  output logic             res_valid,
  output tspcr_pkg::result_t res
);
  import tspcr_pkg::*;

  logic [7:0]        win [0:TAP_DEPTH-1];
  logic [FILL_W-1:0] fill_count;
  logic [LEN_W-1:0]  bytes_left;
  logic [LEN_W-1:0]  current_length;

  logic             full;
  logic             at_boundary;
  logic             sync_188, sync_196, sync_204;
  logic             found;
  logic [LEN_W-1:0] len_sel;
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] left_eff;
  logic             pcr_hit;

  assign full        = (fill_count == FILL_W'(TAP_DEPTH));
  assign at_boundary = (bytes_left == '0);

  // sync byte at the start and one and two lengths on
  assign sync_188 = (win[0] == SYNC_BYTE) && (win[188] == SYNC_BYTE) &&
                    (win[2*188] == SYNC_BYTE);
  assign sync_196 = (win[0] == SYNC_BYTE) && (win[196] == SYNC_BYTE) &&
                    (win[2*196] == SYNC_BYTE);
  assign sync_204 = (win[0] == SYNC_BYTE) && (win[204] == SYNC_BYTE) &&
                    (win[2*204] == SYNC_BYTE);
  assign found    = sync_188 || sync_196 || sync_204;

  always_comb begin
    if (sync_188) begin
      len_sel = LEN_188;
    end else if (sync_196) begin
      len_sel = LEN_196;
    end else begin
      len_sel = LEN_204;
    end
  end

  assign len_eff  = at_boundary ? len_sel : current_length;
  assign left_eff = at_boundary ? len_sel : bytes_left;

  assign pcr_hit = at_boundary && found &&
                   ((win[3] & AF_PRESENT) != '0) &&
                   ((win[5] & PCR_FLAG) != '0) &&
                   (win[4] >= AF_MIN_LENGTH);

  assign res_valid = full && (!at_boundary || found);

  always_comb begin
    res.out_byte      = win[0];
    res.packet_first  = at_boundary;
    res.packet_last   = (left_eff == LEN_W'(1));
    res.packet_length = len_eff;
    res.pcr_valid     = pcr_hit;
    res.pcr_pid       = pcr_hit ? {win[1][4:0] & PID_HI_MASK[4:0], win[2]} : '0;
    res.pcr_base      = pcr_hit ? {win[6], win[7], win[8], win[9], win[10][7]} : '0;
  end

  // shift line, no reset: nothing is read before it has been filled
  always_ff @(posedge clk) begin
    if (in_accept) begin
      for (int i = 0; i < TAP_DEPTH - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[TAP_DEPTH-1] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count     <= '0;
      bytes_left     <= '0;
      current_length <= LEN_188;
    end else if (in_accept) begin
      if (!full) begin
        fill_count <= fill_count + FILL_W'(1);
      end else if (res_valid) begin
        current_length <= len_eff;
        bytes_left     <= left_eff - LEN_W'(1);
      end
    end
  end

endmodule

// File: hw/rtl/ts_packet_sync_pcr_extract_top.sv
// top level of the transport-stream packet synchronizer and pcr extractor
// depends on tspcr_pkg and tspcr_sync
`timescale 1ns / 1ps

// Usage
// - slave stream: one raw transport-stream byte per beat on s_tdata[7:0]
// - master stream: one packet byte per beat; tuser[0] marks the sync byte
//   that opens a packet, tlast the final byte; the first beat also carries
//   the pid and 33-bit pcr base when the adaptation field holds a pcr
// - lengths 188, 196 and 204 are recognized (in that order) by sync bytes at
//   one and two packet lengths ahead of the packet start
// - output: a packet byte is registered, in the output or skid register, by the
//   input beat that pushes it out of the 612-byte lookahead window
// - throughput: one beat per cycle while s_tready is high; the sync check and
//   pcr decode are fixed-position compares on window taps between the window
//   and the output register
// - after reset the window is empty: the first 611 input beats give no
//   output; bytes that fail the sync test at a packet start are dropped,
//   and a tail shorter than the window is never released
// - stall: an output register plus a one-beat skid register; s_tready only
//   drops while the skid register holds a beat, so input keeps flowing after
//   m_tready falls until a beat is pushed into the skid register
module ts_packet_sync_pcr_extract_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [tspcr_pkg::IN_DATA_W-1:0] s_tdata,   // [7:0] data_byte
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [7:0] out_byte, [15:8] packet_length, [28:16] pcr_pid, [61:29] pcr_base,
  // [63:62] zero
  output logic [tspcr_pkg::TDATA_W-1:0]   m_tdata,
  output logic                            m_tlast,   // packet_last
  output logic [tspcr_pkg::TUSER_W-1:0]   m_tuser    // [0] packet_first, [1] pcr_valid
);
  import tspcr_pkg::*;

  logic    in_accept;
  logic    res_valid;
  result_t res;

  // output register and skid register
  result_t out_reg;
  logic    out_valid;
  result_t skid;
  logic    skid_valid;

  logic    pop;
  logic    push;

  assign s_tready  = !skid_valid;
  assign in_accept = s_tvalid && s_tready;

  tspcr_sync u_sync (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .data_byte (s_tdata[7:0]),
    .res_valid (res_valid),
    .res       (res)
  );

  assign pop  = out_valid && m_tready;
  assign push = in_accept && res_valid;

  // skid only fills when the output register is held; s_tready keeps a
  // second push from arriving while skid is occupied
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      if (skid_valid) begin
        out_reg    <= skid;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_reg   <= res;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      skid       <= res;
      skid_valid <= 1'b1;
    end
  end

  // stream packing, lowest field first
  assign m_tvalid = out_valid;
  assign m_tdata  = {{PAD_W{1'b0}}, out_reg.pcr_base, out_reg.pcr_pid,
                     out_reg.packet_length, out_reg.out_byte};
  assign m_tlast  = out_reg.packet_last;
  assign m_tuser  = {out_reg.pcr_valid, out_reg.packet_first};

endmodule

// File: hw/rtl/tspcr_checker.sv
// port-level checker for the transport-stream sync and pcr extractor
// depends on tspcr_pkg and assert_macros.svh; bound to the top level below
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tspcr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [tspcr_pkg::TDATA_W-1:0]   m_tdata,
  input logic                            m_tlast,
  input logic [tspcr_pkg::TUSER_W-1:0]   m_tuser
);
  import tspcr_pkg::*;

  logic                         stalled;
  logic [TDATA_W+TUSER_W:0]     beat;
  logic                         first_beat;
  logic                         pcr_beat;
  logic                         plain_beat;
  logic                         len_ok;

  assign stalled    = m_tvalid && !m_tready;
  assign beat       = {m_tuser, m_tlast, m_tdata};
  assign first_beat = m_tvalid && m_tuser[0];
  assign pcr_beat   = m_tvalid && m_tuser[1];
  assign plain_beat = m_tvalid && !m_tuser[1];
  assign len_ok     = (m_tdata[15:8] == LEN_188) || (m_tdata[15:8] == LEN_196) ||
                      (m_tdata[15:8] == LEN_204);

  // a stalled beat keeps its contents
  `ASSERT_NEXT(a_stall_hold, stalled, m_tvalid && $stable(beat), "stalled beat changed")

  // a packet opens on a sync byte
  `ASSERT_IMPL(a_first_sync, first_beat, m_tdata[7:0] == SYNC_BYTE, "no sync at packet start")

  // pcr only reported on the opening beat
  `ASSERT_IMPL(a_pcr_on_first, pcr_beat, m_tuser[0], "pcr away from packet start")

  // length field is one of the recognized lengths
  `ASSERT_IMPL(a_len_legal, m_tvalid, len_ok, "illegal packet length")

  // pid and pcr base are zero when no pcr is reported
  `ASSERT_IMPL(a_pcr_zero, plain_beat, m_tdata[61:16] == '0, "pcr fields set without pcr")

endmodule

bind ts_packet_sync_pcr_extract_top tspcr_checker u_checker (.*);
